### rtl/rvp_pkg.sv
// Shared widths, constants, tables and stage payload types for the pivot rotator.
package rvp_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 24;
    localparam int GUARD_BITS    = 16;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PHASE_W = 32;
    localparam int Z_W     = PHASE_W + 1;

    // gain compensation: round(2^30 / K), positive and below 2^30
    localparam int GAIN_W     = 30;
    localparam int GPROD_W    = DIFF_W + GAIN_W + 1;
    localparam int GAIN_SHIFT = 30 - GUARD_BITS;
    localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = GAIN_W'(652032874);
    localparam logic signed [GPROD_W-1:0] GAIN_RND = GPROD_W'(1) << (GAIN_SHIFT - 1);

    // CORDIC datapath width, with headroom for the gain of the iterations
    localparam int XY_W  = DIFF_W + GUARD_BITS + 3;
    localparam int RND_W = XY_W - GUARD_BITS;
    localparam int SUM_W = RND_W + 1;
    localparam logic signed [XY_W-1:0] OUT_RND = XY_W'(1) << (GUARD_BITS - 1);

    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // angle to phase scale, 2^32 phase units per turn
    localparam logic [63:0] TURN_PER_DEG_Q64 = 64'd51240955760304310;
    localparam logic [63:0] TURN_PER_RAD_Q64 = 64'd2935890503282001241;
    localparam logic [63:0] K_DEG = TURN_PER_DEG_Q64 >> FRAC_BITS;
    localparam logic [63:0] K_RAD =
        (TURN_PER_RAD_Q64 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

    // scale factor split into two partial products
    localparam int KLO_W = 24;
    localparam int KHI_W = 64 - FRAC_BITS - KLO_W;
    localparam int PLO_W = COORD_W + KLO_W + 1;
    localparam int PHI_W = COORD_W + KHI_W + 1;

    // floor(atan(2^-i) * 2^32 / (2*pi))
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    typedef struct packed {
        logic [PHASE_W-1:0]        phase;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
    } phase_t;

    typedef struct packed {
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic signed [Z_W-1:0]     z;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
    } cordic_t;

    typedef struct packed {
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;
    } rot_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      sat;
    } result_t;

endpackage

### rtl/rvp_phase.sv
// Angle to phase conversion (two-part multiply) and point minus pivot offset.
module rvp_phase (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               deg_mode,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [rvp_pkg::COORD_W-1:0] point_x,
    input  logic signed [rvp_pkg::COORD_W-1:0] point_y,
    input  logic signed [rvp_pkg::COORD_W-1:0] rot_angle,
    input  logic signed [rvp_pkg::COORD_W-1:0] pivot_x,
    input  logic signed [rvp_pkg::COORD_W-1:0] pivot_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output rvp_pkg::phase_t                    out_data
);

    logic [1:0] vld_reg;
    logic [1:0] vld_next;
    logic [2:0] go;

    logic [63:0]                        k;
    logic [rvp_pkg::KLO_W-1:0]          k_lo;
    logic [rvp_pkg::KHI_W-1:0]          k_hi;
    logic signed [rvp_pkg::PLO_W-1:0]   plo_reg, plo_next;
    logic signed [rvp_pkg::PHI_W-1:0]   phi_reg, phi_next;
    logic signed [rvp_pkg::DIFF_W-1:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic signed [rvp_pkg::COORD_W-1:0] qx_reg, qy_reg;
    logic [63:0]                        full;
    rvp_pkg::phase_t                    out_reg, out_next;

    assign go[2] = out_ready;
    assign go[1] = !vld_reg[1] || go[2];
    assign go[0] = !vld_reg[0] || go[1];
    assign in_ready  = go[0];
    assign out_valid = vld_reg[1];
    assign out_data  = out_reg;

    assign vld_next = (go[1:0] & {vld_reg[0], in_valid}) | (~go[1:0] & vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_comb begin
        k        = deg_mode ? rvp_pkg::K_DEG : rvp_pkg::K_RAD;
        k_lo     = k[rvp_pkg::KLO_W-1:0];
        k_hi     = k[rvp_pkg::KLO_W+rvp_pkg::KHI_W-1:rvp_pkg::KLO_W];
        plo_next = rot_angle * $signed({1'b0, k_lo});
        phi_next = rot_angle * $signed({1'b0, k_hi});
        dx_next  = rvp_pkg::DIFF_W'(point_x) - rvp_pkg::DIFF_W'(pivot_x);
        dy_next  = rvp_pkg::DIFF_W'(point_y) - rvp_pkg::DIFF_W'(pivot_y);
    end

    always_ff @(posedge aclk) begin
        if (go[0]) begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            qx_reg  <= pivot_x;
            qy_reg  <= pivot_y;
        end
    end

    // product modulo 2^64; the upper word is the phase
    always_comb begin
        full           = 64'(plo_reg) + (64'(phi_reg) << rvp_pkg::KLO_W);
        out_next.phase = full[63:64-rvp_pkg::PHASE_W];
        out_next.dx    = dx_reg;
        out_next.dy    = dy_reg;
        out_next.qx    = qx_reg;
        out_next.qy    = qy_reg;
    end

    always_ff @(posedge aclk) begin
        if (go[1]) begin
            out_reg <= out_next;
        end
    end

endmodule

### rtl/rvp_prescale.sv
// Half-turn fold of the phase and gain compensation of the offset vector.
module rvp_prescale (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rvp_pkg::phase_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rvp_pkg::cordic_t out_data
);

    logic [2:0] vld_reg;
    logic [2:0] vld_next;
    logic [3:0] go;

    logic                               flip;
    logic [rvp_pkg::PHASE_W-1:0]        phase_f;
    logic signed [rvp_pkg::DIFF_W-1:0]  dxf_reg, dxf_next, dyf_reg, dyf_next;
    logic signed [rvp_pkg::Z_W-1:0]     z1_reg, z1_next, z2_reg;
    logic signed [rvp_pkg::COORD_W-1:0] qx1_reg, qy1_reg, qx2_reg, qy2_reg;
    logic signed [rvp_pkg::GPROD_W-1:0] gx_reg, gx_next, gy_reg, gy_next;
    logic signed [rvp_pkg::GPROD_W-1:0] xr, yr;
    rvp_pkg::cordic_t                   out_reg, out_next;

    assign go[3] = out_ready;
    assign go[2] = !vld_reg[2] || go[3];
    assign go[1] = !vld_reg[1] || go[2];
    assign go[0] = !vld_reg[0] || go[1];
    assign in_ready  = go[0];
    assign out_valid = vld_reg[2];
    assign out_data  = out_reg;

    assign vld_next = (go[2:0] & {vld_reg[1:0], in_valid}) | (~go[2:0] & vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // second and third quarter: turn by half a turn and negate the offset
    always_comb begin
        flip     = in_data.phase[rvp_pkg::PHASE_W-1] ^ in_data.phase[rvp_pkg::PHASE_W-2];
        phase_f  = {in_data.phase[rvp_pkg::PHASE_W-1] ^ flip,
                    in_data.phase[rvp_pkg::PHASE_W-2:0]};
        z1_next  = rvp_pkg::Z_W'($signed(phase_f));
        dxf_next = flip ? -in_data.dx : in_data.dx;
        dyf_next = flip ? -in_data.dy : in_data.dy;
    end

    always_ff @(posedge aclk) begin
        if (go[0]) begin
            dxf_reg <= dxf_next;
            dyf_reg <= dyf_next;
            z1_reg  <= z1_next;
            qx1_reg <= in_data.qx;
            qy1_reg <= in_data.qy;
        end
    end

    always_comb begin
        gx_next = dxf_reg * $signed({1'b0, rvp_pkg::INV_GAIN_Q30});
        gy_next = dyf_reg * $signed({1'b0, rvp_pkg::INV_GAIN_Q30});
    end

    always_ff @(posedge aclk) begin
        if (go[1]) begin
            gx_reg  <= gx_next;
            gy_reg  <= gy_next;
            z2_reg  <= z1_reg;
            qx2_reg <= qx1_reg;
            qy2_reg <= qy1_reg;
        end
    end

    // round half up into the guard-bit format
    always_comb begin
        xr          = (gx_reg + rvp_pkg::GAIN_RND) >>> rvp_pkg::GAIN_SHIFT;
        yr          = (gy_reg + rvp_pkg::GAIN_RND) >>> rvp_pkg::GAIN_SHIFT;
        out_next.x  = $signed(xr[rvp_pkg::XY_W-1:0]);
        out_next.y  = $signed(yr[rvp_pkg::XY_W-1:0]);
        out_next.z  = z2_reg;
        out_next.qx = qx2_reg;
        out_next.qy = qy2_reg;
    end

    always_ff @(posedge aclk) begin
        if (go[2]) begin
            out_reg <= out_next;
        end
    end

endmodule

### rtl/rvp_cordic.sv
// Unrolled CORDIC rotation, one micro-rotation per register stage.
module rvp_cordic (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rvp_pkg::cordic_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rvp_pkg::rot_t    out_data
);

    localparam int N = rvp_pkg::CORDIC_STAGES;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_next;
    logic [N:0]   go;

    logic signed [rvp_pkg::XY_W-1:0]    x_reg  [N];
    logic signed [rvp_pkg::XY_W-1:0]    y_reg  [N];
    logic signed [rvp_pkg::Z_W-1:0]     z_reg  [N-1];
    logic signed [rvp_pkg::COORD_W-1:0] qx_reg [N];
    logic signed [rvp_pkg::COORD_W-1:0] qy_reg [N];

    assign go[N]     = out_ready;
    assign in_ready  = go[0];
    assign out_valid = vld_reg[N-1];

    assign vld_next = (go[N-1:0] & {vld_reg[N-2:0], in_valid}) | (~go[N-1:0] & vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic signed [rvp_pkg::Z_W-1:0] ATAN_I =
            rvp_pkg::Z_W'(rvp_pkg::ATAN_TURNS[i]);

        logic signed [rvp_pkg::XY_W-1:0]    xi, yi, xs, ys, x_next, y_next;
        logic signed [rvp_pkg::Z_W-1:0]     zi, z_next;
        logic signed [rvp_pkg::COORD_W-1:0] qxi, qyi;

        assign go[i] = !vld_reg[i] || go[i+1];

        if (i == 0) begin : g_first
            assign xi  = in_data.x;
            assign yi  = in_data.y;
            assign zi  = in_data.z;
            assign qxi = in_data.qx;
            assign qyi = in_data.qy;
        end else begin : g_rest
            assign xi  = x_reg[i-1];
            assign yi  = y_reg[i-1];
            assign zi  = z_reg[i-1];
            assign qxi = qx_reg[i-1];
            assign qyi = qy_reg[i-1];
        end

        // turn towards zero residual angle
        always_comb begin
            xs = xi >>> i;
            ys = yi >>> i;
            if (!zi[rvp_pkg::Z_W-1]) begin
                x_next = xi - ys;
                y_next = yi + xs;
                z_next = zi - ATAN_I;
            end else begin
                x_next = xi + ys;
                y_next = yi - xs;
                z_next = zi + ATAN_I;
            end
        end

        always_ff @(posedge aclk) begin
            if (go[i]) begin
                x_reg[i]  <= x_next;
                y_reg[i]  <= y_next;
                qx_reg[i] <= qxi;
                qy_reg[i] <= qyi;
            end
        end

        // the residual angle after the last stage is dropped
        if (i < N - 1) begin : g_z
            always_ff @(posedge aclk) begin
                if (go[i]) begin
                    z_reg[i] <= z_next;
                end
            end
        end
    end

    assign out_data.x  = x_reg[N-1];
    assign out_data.y  = y_reg[N-1];
    assign out_data.qx = qx_reg[N-1];
    assign out_data.qy = qy_reg[N-1];

endmodule

### rtl/rvp_round.sv
// Rounding back to the coordinate format, pivot add and saturation.
module rvp_round (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rvp_pkg::rot_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rvp_pkg::result_t out_data
);

    logic [1:0] vld_reg;
    logic [1:0] vld_next;
    logic [2:0] go;

    logic signed [rvp_pkg::XY_W-1:0]  xsh, ysh;
    logic signed [rvp_pkg::SUM_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic                             hi_x, lo_x, hi_y, lo_y;
    rvp_pkg::result_t                 out_reg, out_next;

    assign go[2] = out_ready;
    assign go[1] = !vld_reg[1] || go[2];
    assign go[0] = !vld_reg[0] || go[1];
    assign in_ready  = go[0];
    assign out_valid = vld_reg[1];
    assign out_data  = out_reg;

    assign vld_next = (go[1:0] & {vld_reg[0], in_valid}) | (~go[1:0] & vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_comb begin
        xsh     = (in_data.x + rvp_pkg::OUT_RND) >>> rvp_pkg::GUARD_BITS;
        ysh     = (in_data.y + rvp_pkg::OUT_RND) >>> rvp_pkg::GUARD_BITS;
        sx_next = rvp_pkg::SUM_W'($signed(xsh[rvp_pkg::RND_W-1:0]))
                + rvp_pkg::SUM_W'(in_data.qx);
        sy_next = rvp_pkg::SUM_W'($signed(ysh[rvp_pkg::RND_W-1:0]))
                + rvp_pkg::SUM_W'(in_data.qy);
    end

    always_ff @(posedge aclk) begin
        if (go[0]) begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    // clip when the bits above the coordinate are not all copies of its sign
    always_comb begin
        hi_x = !sx_reg[rvp_pkg::SUM_W-1]
            && (sx_reg[rvp_pkg::SUM_W-2:rvp_pkg::COORD_W-1] != '0);
        lo_x = sx_reg[rvp_pkg::SUM_W-1]
            && (sx_reg[rvp_pkg::SUM_W-2:rvp_pkg::COORD_W-1] != '1);
        hi_y = !sy_reg[rvp_pkg::SUM_W-1]
            && (sy_reg[rvp_pkg::SUM_W-2:rvp_pkg::COORD_W-1] != '0);
        lo_y = sy_reg[rvp_pkg::SUM_W-1]
            && (sy_reg[rvp_pkg::SUM_W-2:rvp_pkg::COORD_W-1] != '1);
        priority if (hi_x) begin
            out_next.x = rvp_pkg::COORD_MAX;
        end else if (lo_x) begin
            out_next.x = rvp_pkg::COORD_MIN;
        end else begin
            out_next.x = sx_reg[rvp_pkg::COORD_W-1:0];
        end
        priority if (hi_y) begin
            out_next.y = rvp_pkg::COORD_MAX;
        end else if (lo_y) begin
            out_next.y = rvp_pkg::COORD_MIN;
        end else begin
            out_next.y = sy_reg[rvp_pkg::COORD_W-1:0];
        end
        out_next.sat = hi_x | lo_x | hi_y | lo_y;
    end

    always_ff @(posedge aclk) begin
        if (go[1]) begin
            out_reg <= out_next;
        end
    end

endmodule

### rtl/vector_rotate_about_pivot.sv
// Top level: rotates a Q16.16 point about a pivot by an angle in degrees or radians.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    point_x, point_y, rot_angle, pivot_x, pivot_y
//   m_        out        m_valid/m_ready    rotated_x, rotated_y, saturated
//   cfg_      in         cfg_wr_en          cfg_wr_data (angle_in_degrees)
//
// One beat per cycle while m_ready is high; the pipeline is made up of the two-stage
// phase multiply, three-stage fold and gain scaling, one register per CORDIC
// micro-rotation and two stages of rounding and saturation.
// Every stage has its own valid bit and takes a new beat whenever it is empty or
// its content moves on, so a stall on m_ready fills bubbles before s_ready drops.
// Reset (aresetn low, synchronous) empties the pipeline and sets degree mode.
module vector_rotate_about_pivot (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [rvp_pkg::COORD_W-1:0] s_point_x,
    input  logic signed [rvp_pkg::COORD_W-1:0] s_point_y,
    input  logic signed [rvp_pkg::COORD_W-1:0] s_rot_angle,
    input  logic signed [rvp_pkg::COORD_W-1:0] s_pivot_x,
    input  logic signed [rvp_pkg::COORD_W-1:0] s_pivot_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [rvp_pkg::COORD_W-1:0] m_rotated_x,
    output logic signed [rvp_pkg::COORD_W-1:0] m_rotated_y,
    output logic                               m_saturated
);

    logic             angle_in_degrees_reg;
    logic             angle_in_degrees_next;

    logic             ph_valid, ph_ready;
    rvp_pkg::phase_t  ph_data;
    logic             pre_valid, pre_ready;
    rvp_pkg::cordic_t pre_data;
    logic             rot_valid, rot_ready;
    rvp_pkg::rot_t    rot_data;
    rvp_pkg::result_t res_data;

    assign angle_in_degrees_next = cfg_wr_en ? cfg_wr_data : angle_in_degrees_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_in_degrees_reg <= 1'b1;
        end else begin
            angle_in_degrees_reg <= angle_in_degrees_next;
        end
    end

    rvp_phase u_phase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .deg_mode  (angle_in_degrees_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .point_x   (s_point_x),
        .point_y   (s_point_y),
        .rot_angle (s_rot_angle),
        .pivot_x   (s_pivot_x),
        .pivot_y   (s_pivot_y),
        .out_valid (ph_valid),
        .out_ready (ph_ready),
        .out_data  (ph_data)
    );

    rvp_prescale u_prescale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ph_valid),
        .in_ready  (ph_ready),
        .in_data   (ph_data),
        .out_valid (pre_valid),
        .out_ready (pre_ready),
        .out_data  (pre_data)
    );

    rvp_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pre_valid),
        .in_ready  (pre_ready),
        .in_data   (pre_data),
        .out_valid (rot_valid),
        .out_ready (rot_ready),
        .out_data  (rot_data)
    );

    rvp_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rot_valid),
        .in_ready  (rot_ready),
        .in_data   (rot_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_data)
    );

    assign m_rotated_x = res_data.x;
    assign m_rotated_y = res_data.y;
    assign m_saturated = res_data.sat;

endmodule

### dv/testbench.sv
// Self-checking testbench for the pivot rotator: directed angles, random points, stalls.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W     = rvp_pkg::COORD_W;

    localparam int ROT_STAGES  = 24;
    localparam int TAIL_CYCLES = 2 * (7 + ROT_STAGES);
    localparam int CYCLE_LIMIT = 400000;
    localparam int ONE         = 65536;           // 1.0 in Q16.16
    localparam int COORD_SPAN  = 1000 * ONE;
    localparam int RAD_SPAN    = 823550;          // about 4*pi
    localparam int HALF_PI     = 102944;
    localparam int PI_Q16      = 205887;

    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

    localparam logic [63:0] DEG_TURN_Q64 = 64'd51240955760304310;
    localparam logic [63:0] RAD_TURN_Q64 = 64'd2935890503282001241;
    localparam logic [63:0] DEG_SCALE    = DEG_TURN_Q64 >> 16;
    localparam logic [63:0] RAD_SCALE    = (RAD_TURN_Q64 + 64'd32768) >> 16;
    localparam longint      GAIN_Q30     = 64'sd652032874;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] rot_angle;
        logic signed [COORD_W-1:0] pivot_x;
        logic signed [COORD_W-1:0] pivot_y;
    } point_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rotated_x;
        logic signed [COORD_W-1:0] rotated_y;
        logic                      saturated;
    } rot_result_t;

    // phase units per micro-rotation, 2^32 per turn
    logic [31:0] arctan_turns [ROT_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic signed [COORD_W-1:0] m_rotated_x;
    logic signed [COORD_W-1:0] m_rotated_y;
    logic        m_saturated;
    point_item_t tx_item     = '0;

    rot_result_t pending_rotations [$];
    bit          angle_deg_mode = 1'b1;
    int          tx_idle_pct    = 0;
    int          rx_idle_pct    = 0;
    int          hold_left      = 0;
    int          fail_count     = 0;
    int          cycle_count    = 0;

    vector_rotate_about_pivot DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_point_x   (tx_item.point_x),
        .s_point_y   (tx_item.point_y),
        .s_rot_angle (tx_item.rot_angle),
        .s_pivot_x   (tx_item.pivot_x),
        .s_pivot_y   (tx_item.pivot_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rotated_x (m_rotated_x),
        .m_rotated_y (m_rotated_y),
        .m_saturated (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic rot_result_t rotate_about_pivot(input point_item_t it, input bit in_deg);
        longint      dx, dy, x, y, z, xs, ys;
        logic [63:0] angle64, prod;
        logic [31:0] phase;
        rot_result_t r;
        dx = longint'(it.point_x) - longint'(it.pivot_x);
        dy = longint'(it.point_y) - longint'(it.pivot_y);
        angle64 = longint'(it.rot_angle);
        prod = angle64 * (in_deg ? DEG_SCALE : RAD_SCALE);
        phase = prod[63:32];
        // fold the second and third quarter turns onto the first and fourth
        if (phase[31:30] == 2'b01 || phase[31:30] == 2'b10) begin
            dx = -dx;
            dy = -dy;
            phase = phase + 32'h8000_0000;
        end
        z = $signed(phase);
        x = (dx * GAIN_Q30 + (longint'(1) << 13)) >>> 14;
        y = (dy * GAIN_Q30 + (longint'(1) << 13)) >>> 14;
        for (int i = 0; i < ROT_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(arctan_turns[i]);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(arctan_turns[i]);
            end
        end
        x = ((x + (longint'(1) << 15)) >>> 16) + longint'(it.pivot_x);
        y = ((y + (longint'(1) << 15)) >>> 16) + longint'(it.pivot_y);
        r.saturated = 1'b0;
        if (x > longint'(C_MAX)) begin
            x = C_MAX;
            r.saturated = 1'b1;
        end else if (x < longint'(C_MIN)) begin
            x = C_MIN;
            r.saturated = 1'b1;
        end
        if (y > longint'(C_MAX)) begin
            y = C_MAX;
            r.saturated = 1'b1;
        end else if (y < longint'(C_MIN)) begin
            y = C_MIN;
            r.saturated = 1'b1;
        end
        r.rotated_x = x[31:0];
        r.rotated_y = y[31:0];
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return $urandom_range(0, 2 * COORD_SPAN) - COORD_SPAN;
        else if (pick < 75)
            return $urandom;
        else if (pick < 90)
            return ($urandom_range(0, 1) ? C_MAX : C_MIN) ^ $urandom_range(0, 16 * ONE);
        else
            return '0;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_angle(input bit in_deg);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return in_deg ? $urandom_range(0, 1440 * ONE) - 720 * ONE
                          : $urandom_range(0, 2 * RAD_SPAN) - RAD_SPAN;
        else if (pick < 65)
            return ($urandom_range(0, 16) - 8) * (in_deg ? 90 * ONE : HALF_PI);
        else if (pick < 85)
            return $urandom;
        else
            return $urandom_range(0, 2 * ONE) - ONE;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (fail_count < 100)
            $display("mismatch at cycle %0d: %s expected %h got %h",
                     cycle_count, what, want, got);
        fail_count++;
    endtask

    // scoreboard: predict on each accepted input beat, check each result beat
    always @(posedge aclk) begin : scoreboard
        rot_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_rotations.size() == 0) begin
                    report_mismatch("unexpected result, x", '0, m_rotated_x);
                end else begin
                    want = pending_rotations.pop_front();
                    if (m_rotated_x !== want.rotated_x)
                        report_mismatch("rotated_x", want.rotated_x, m_rotated_x);
                    if (m_rotated_y !== want.rotated_y)
                        report_mismatch("rotated_y", want.rotated_y, m_rotated_y);
                    if (m_saturated !== want.saturated)
                        report_mismatch("saturated", {31'b0, want.saturated},
                                        {31'b0, m_saturated});
                end
            end
            if (s_valid && s_ready)
                pending_rotations.push_back(rotate_about_pivot(tx_item, angle_deg_mode));
            if (cfg_wr_en)
                angle_deg_mode = cfg_wr_data;
        end
    end

    // receiver: long hold-off when asked, otherwise random stalls
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic offer_point(input point_item_t it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        tx_item <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    task automatic offer_fields(input logic signed [COORD_W-1:0] px, py, ang, qx, qy);
        point_item_t it;
        it = '{point_x: px, point_y: py, rot_angle: ang, pivot_x: qx, pivot_y: qy};
        offer_point(it);
    endtask

    task automatic await_rotations_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_rotations.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_angle_mode(input bit in_deg);
        await_rotations_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= in_deg;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic test_directed_degrees();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        offer_fields(0, 0, 0, 0, 0);
        offer_fields(ONE, 0, 0, 0, 0);
        offer_fields(ONE, 0, 90 * ONE, 0, 0);
        offer_fields(ONE, 0, 180 * ONE, 0, 0);
        offer_fields(ONE, 0, 270 * ONE, 0, 0);
        offer_fields(ONE, 0, -90 * ONE, 0, 0);
        // one full turn and beyond
        offer_fields(ONE, 0, 360 * ONE, 0, 0);
        offer_fields(ONE, ONE, 765 * ONE, 0, 0);
        offer_fields(100 * ONE, -50 * ONE, C_MAX, 3 * ONE, 7 * ONE);
        offer_fields(100 * ONE, -50 * ONE, C_MIN, 3 * ONE, 7 * ONE);
        offer_fields(20 * ONE, 10 * ONE, 90 * ONE, 10 * ONE, 10 * ONE);
        // widest offsets, clipping in both directions
        offer_fields(C_MAX, C_MAX, 0, C_MIN, C_MIN);
        offer_fields(C_MAX, C_MAX, 180 * ONE, C_MIN, C_MIN);
        offer_fields(C_MIN, C_MIN, 180 * ONE, C_MAX, C_MAX);
        offer_fields(C_MAX, C_MIN, 45 * ONE, 0, 0);
        await_rotations_drained();
    endtask

    task automatic test_directed_radians();
        set_angle_mode(1'b0);
        offer_fields(ONE, 0, HALF_PI, 0, 0);
        offer_fields(ONE, 0, PI_Q16, 0, 0);
        offer_fields(ONE, 0, -PI_Q16, 0, 0);
        offer_fields(ONE, 0, 2 * PI_Q16, 0, 0);
        offer_fields(-7 * ONE, 3 * ONE, C_MAX, ONE, -ONE);
        offer_fields(-7 * ONE, 3 * ONE, C_MIN, ONE, -ONE);
        offer_fields(C_MIN, C_MIN, PI_Q16 / 4, C_MAX, C_MAX);
        await_rotations_drained();
    endtask

    task automatic test_random_rotations(input int tx_pct, input int rx_pct, input int count);
        point_item_t it;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int half = 0; half < 2; half++) begin
            set_angle_mode(half == 0);
            for (int n = 0; n < count / 2; n++) begin
                it.point_x   = rand_coord();
                it.point_y   = rand_coord();
                it.rot_angle = rand_angle(half == 0);
                if ($urandom_range(0, 99) < 20) begin
                    it.pivot_x = '0;
                    it.pivot_y = '0;
                end else begin
                    it.pivot_x = rand_coord();
                    it.pivot_y = rand_coord();
                end
                offer_point(it);
            end
        end
        await_rotations_drained();
    endtask

    task automatic test_backpressure();
        point_item_t it;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // hold the result side long enough for the pipeline to fill and stall input
        @(posedge aclk);
        hold_left = 300;
        @(negedge aclk);
        for (int n = 0; n < 120; n++) begin
            it = '{point_x: rand_coord(), point_y: rand_coord(),
                   rot_angle: rand_angle(angle_deg_mode),
                   pivot_x: rand_coord(), pivot_y: rand_coord()};
            offer_point(it);
            if (n == 79)
                await_rotations_drained();
        end
        await_rotations_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_degrees();
        test_directed_radians();
        test_random_rotations(31, 74, 330);
        test_random_rotations(74, 31, 330);
        test_random_rotations(0, 0, 350);
        test_backpressure();
        await_rotations_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/rvp_pkg.sv
rtl/rvp_phase.sv
rtl/rvp_prescale.sv
rtl/rvp_cordic.sv
rtl/rvp_round.sv
rtl/vector_rotate_about_pivot.sv
dv/testbench.sv
